>>> rtl/core/bmct_pkg.sv
package bmct_pkg;

  // Default memory sizes
  localparam int WORK_RAM_BYTES_DEF    = 8192;
  localparam int PATTERN_RAM_BYTES_DEF = 8192;

  // Bus commands
  localparam logic [2:0] CMD_CPU_RD = 3'd0;
  localparam logic [2:0] CMD_CPU_WR = 3'd1;
  localparam logic [2:0] CMD_PPU_RD = 3'd2;
  localparam logic [2:0] CMD_PPU_WR = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // ROM fetch kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PRG  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  // Configuration register indexes
  localparam int          CFG_AW        = 4;
  localparam logic [1:0]  CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0]  CFG_CHR_COUNT = 2'd1;
  localparam logic [1:0]  CFG_CHR_IS_RAM = 2'd2;
  localparam logic [1:0]  CFG_MIRROR    = 2'd3;

  // Register decode
  localparam logic [15:0] DECODE_MASK  = 16'hF03D;
  localparam logic [15:0] ADDR_PRG0    = 16'h8000;
  localparam logic [15:0] ADDR_PRG1    = 16'h8008;
  localparam logic [15:0] ADDR_PRG2    = 16'h9000;
  localparam logic [15:0] ADDR_MIRROR  = 16'hB000;
  localparam logic [15:0] ADDR_CHR0    = 16'hC000;
  localparam logic [15:0] ADDR_CHR1    = 16'hC004;
  localparam logic [15:0] ADDR_CHR2    = 16'hC008;
  localparam logic [15:0] ADDR_CHR3    = 16'hC00C;
  localparam logic [15:0] ADDR_CHR4    = 16'hD000;
  localparam logic [15:0] ADDR_CHR5    = 16'hD004;
  localparam logic [15:0] ADDR_CHR6    = 16'hD008;
  localparam logic [15:0] ADDR_CHR7    = 16'hD00C;
  localparam logic [15:0] ADDR_IRQ_LATCH = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_CTRL  = 16'hE008;
  localparam logic [15:0] ADDR_IRQ_ACK   = 16'hE010;
  localparam int          IRQ_RESTART_BIT = 1;

  // Remainder unit widths: 13-bit dividend, 14-bit divisor
  localparam int REM_DW = 13;
  localparam int REM_RW = 14;

  // Register block request and status
  typedef struct packed {
    logic        wr;
    logic        tick;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        mirror_load;
    logic        mirror_val;
  } bmct_reg_req_t;

  typedef struct packed {
    logic [2:0][5:0] prg;
    logic [7:0][7:0] chr;
    logic            irq_flag;
    logic            mirror;
  } bmct_reg_stat_t;

  // Bank count as used: zero reads as one, above 256 reads as 256
  function automatic logic [8:0] usable_count(logic [8:0] n);
    logic [8:0] r;
    r = n;
    if (n == 9'd0) r = 9'd1;
    else if (n[8] && (n[7:0] != 8'd0)) r = 9'd256;
    return r;
  endfunction

endpackage

>>> rtl/core/bmct_rem.sv
module bmct_rem
  import bmct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [REM_DW-1:0] dividend,
  input  logic [REM_RW-1:0] divisor,
  output logic              busy,
  output logic [REM_RW-1:0] rem
);

  localparam int CW = $clog2(REM_DW + 1);

  logic [REM_RW-1:0] rem_r, rem_nxt;
  logic [REM_RW-1:0] div_r, div_nxt;
  logic [REM_DW-1:0] quo_r, quo_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [REM_RW-1:0] trial;

  // One restoring step per cycle, MSB of dividend first
  always_comb begin
    trial    = {rem_r[REM_RW-2:0], quo_r[REM_DW-1]};
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(REM_DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = (trial >= div_r) ? (trial - div_r) : trial;
      quo_nxt  = {quo_r[REM_DW-2:0], 1'b0};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/bmct_ram.sv
module bmct_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else    rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bmct_regs.sv
module bmct_regs
  import bmct_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  bmct_reg_req_t  req,
  output bmct_reg_stat_t stat
);

  logic [2:0][5:0] prg_r, prg_nxt;
  logic [7:0][7:0] chr_r, chr_nxt;
  logic            mirror_r, mirror_nxt;
  logic [15:0]     reload_r, reload_nxt;
  logic [15:0]     count_r, count_nxt;
  logic            toggle_r, toggle_nxt;
  logic            irq_en_r, irq_en_nxt;
  logic            irq_flag_r, irq_flag_nxt;

  // Register writes, mirroring load and timer tick
  always_comb begin
    prg_nxt      = prg_r;
    chr_nxt      = chr_r;
    mirror_nxt   = mirror_r;
    reload_nxt   = reload_r;
    count_nxt    = count_r;
    toggle_nxt   = toggle_r;
    irq_en_nxt   = irq_en_r;
    irq_flag_nxt = irq_flag_r;
    if (req.mirror_load) mirror_nxt = req.mirror_val;
    if (req.wr) begin
      case (req.addr & DECODE_MASK)
        ADDR_PRG0:   prg_nxt[0] = req.data[5:0];
        ADDR_PRG1:   prg_nxt[1] = req.data[5:0];
        ADDR_PRG2:   prg_nxt[2] = req.data[5:0];
        ADDR_MIRROR: mirror_nxt = req.data[0];
        ADDR_CHR0:   chr_nxt[0] = req.data;
        ADDR_CHR1:   chr_nxt[1] = req.data;
        ADDR_CHR2:   chr_nxt[2] = req.data;
        ADDR_CHR3:   chr_nxt[3] = req.data;
        ADDR_CHR4:   chr_nxt[4] = req.data;
        ADDR_CHR5:   chr_nxt[5] = req.data;
        ADDR_CHR6:   chr_nxt[6] = req.data;
        ADDR_CHR7:   chr_nxt[7] = req.data;
        ADDR_IRQ_LATCH: begin
          // low byte first, then high byte
          if (!toggle_r) reload_nxt[7:0]  = req.data;
          else           reload_nxt[15:8] = req.data;
          toggle_nxt = ~toggle_r;
        end
        ADDR_IRQ_CTRL: begin
          if (req.data[IRQ_RESTART_BIT]) begin
            irq_en_nxt   = 1'b1;
            irq_flag_nxt = 1'b0;
            count_nxt    = reload_r;
          end else if (req.data[0]) begin
            irq_en_nxt = 1'b1;
            count_nxt  = reload_r;
          end else begin
            irq_en_nxt = 1'b0;
          end
        end
        ADDR_IRQ_ACK: irq_flag_nxt = 1'b0;
        default: ;
      endcase
    end
    if (req.tick) begin
      if (count_r == 16'd0) begin
        count_nxt = reload_r;
        if (irq_en_r) irq_flag_nxt = 1'b1;
      end else begin
        count_nxt = count_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r      <= '0;
      chr_r      <= '0;
      mirror_r   <= 1'b0;
      reload_r   <= '0;
      count_r    <= '0;
      toggle_r   <= 1'b0;
      irq_en_r   <= 1'b0;
      irq_flag_r <= 1'b0;
    end else begin
      prg_r      <= prg_nxt;
      chr_r      <= chr_nxt;
      mirror_r   <= mirror_nxt;
      reload_r   <= reload_nxt;
      count_r    <= count_nxt;
      toggle_r   <= toggle_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_flag_r <= irq_flag_nxt;
    end
  end

  assign stat.prg      = prg_r;
  assign stat.chr      = chr_r;
  assign stat.irq_flag = irq_flag_r;
  assign stat.mirror   = mirror_r;

endmodule

>>> rtl/core/bank_mapper_with_cycle_irq_timer_top.sv
// Cartridge bank mapper with a CPU-cycle IRQ timer. Each input word is one bus
// event (CPU read/write, PPU read/write, or one CPU clock tick) and yields one
// result word: a banked ROM byte address, a work/pattern RAM byte, plus the
// current IRQ level and mirroring. Events are handled one at a time; events that
// need a bank reduced modulo the bank count (program ROM reads outside the fixed
// top window, and every PPU access) also pass through the shared
// one-bit-per-cycle remainder unit. The work RAM index is folded into the RAM
// size by combinational compare and subtract. The result sits in an output
// register, so the next event is taken while it waits; a result still waiting
// when the following event finishes holds that event until the output drains.
// After reset both RAMs are zeroed by a clearing pass over max(WORK_RAM_BYTES,
// PATTERN_RAM_BYTES) addresses (8192 by default) during which no event is
// accepted; configuration writes are taken throughout.
module bank_mapper_with_cycle_irq_timer_top
  import bmct_pkg::*;
#(
  parameter int WORK_RAM_BYTES    = WORK_RAM_BYTES_DEF,
  parameter int PATTERN_RAM_BYTES = PATTERN_RAM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // address[15:0], write_data[23:16]
  input  logic [2:0]        in_tuser,   // command[2:0]
  // result words
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // read_data[7:0], rom_address[28:8],
                                        // irq_line[29], horiz_mirror[30]
  output logic [2:0]        out_tuser,  // read_valid[0], rom_kind[2:1]
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int WAW       = $clog2(WORK_RAM_BYTES);
  localparam int PAW       = $clog2(PATTERN_RAM_BYTES);
  localparam int MAX_BYTES = (WORK_RAM_BYTES > PATTERN_RAM_BYTES) ?
                             WORK_RAM_BYTES : PATTERN_RAM_BYTES;
  localparam int CAW       = $clog2(MAX_BYTES);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MEM  = 5'b01000,
    ST_DONE = 5'b10000
  } bmct_state_t;

  bmct_state_t state_r, state_nxt;

  // Configuration registers
  logic [8:0] prg_cnt_r, chr_cnt_r;
  logic       chr_ram_r, mirror_rst_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_cnt_r    <= 9'd2;
      chr_cnt_r    <= 9'd8;
      chr_ram_r    <= 1'b1;
      mirror_rst_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        CFG_PRG_COUNT:  prg_cnt_r    <= cfg_pwdata[8:0];
        CFG_CHR_COUNT:  chr_cnt_r    <= cfg_pwdata[8:0];
        CFG_CHR_IS_RAM: chr_ram_r    <= cfg_pwdata[0];
        CFG_MIRROR:     mirror_rst_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      CFG_PRG_COUNT:  cfg_prdata = {23'd0, prg_cnt_r};
      CFG_CHR_COUNT:  cfg_prdata = {23'd0, chr_cnt_r};
      CFG_CHR_IS_RAM: cfg_prdata = {31'd0, chr_ram_r};
      CFG_MIRROR:     cfg_prdata = {31'd0, mirror_rst_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // RAM clearing pass after reset
  logic [CAW-1:0] clr_cnt_r;
  logic           clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + CAW'(1);
      if (clr_cnt_r == CAW'(MAX_BYTES - 1)) clr_busy_r <= 1'b0;
    end
  end

  // Latched event
  logic [2:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic        in_acc;

  assign in_tready = (state_r == ST_IDLE) && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_tuser;
      addr_r <= in_tdata[15:0];
      data_r <= in_tdata[23:16];
    end
  end

  // Register block
  bmct_reg_req_t  reg_req;
  bmct_reg_stat_t reg_stat;

  bmct_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (reg_req),
    .stat  (reg_stat)
  );

  // Address decode on the latched event
  logic       ram_range, prg_fixed;
  logic [1:0] prg_slot;
  logic [8:0] prg_cnt_u, chr_cnt_u;
  logic [5:0] prg_bank;
  logic [7:0] chr_bank;

  assign ram_range = (addr_r[15:13] == 3'b011);
  assign prg_slot  = addr_r[14:13];
  assign prg_fixed = (prg_slot == 2'd3);
  assign prg_cnt_u = usable_count(prg_cnt_r);
  assign chr_cnt_u = usable_count(chr_cnt_r);
  assign chr_bank  = reg_stat.chr[addr_r[12:10]];

  always_comb begin
    case (prg_slot)
      2'd0:    prg_bank = reg_stat.prg[0];
      2'd1:    prg_bank = reg_stat.prg[1];
      2'd2:    prg_bank = reg_stat.prg[2];
      default: prg_bank = '0;
    endcase
  end

  // Remainder operand select
  logic              div_start, div_need, div_busy;
  logic [REM_DW-1:0] div_a;
  logic [REM_RW-1:0] div_b, rem;

  always_comb begin
    div_need = 1'b0;
    div_a    = '0;
    div_b    = REM_RW'(1);
    case (cmd_r)
      CMD_CPU_RD: begin
        if (addr_r[15] && !prg_fixed) begin
          div_need = 1'b1;
          div_a    = REM_DW'(prg_bank);
          div_b    = REM_RW'(prg_cnt_u);
        end
      end
      CMD_PPU_RD, CMD_PPU_WR: begin
        div_need = 1'b1;
        div_a    = REM_DW'(chr_bank);
        div_b    = REM_RW'(chr_cnt_u);
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == ST_LOAD) && div_need;

  bmct_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .rem      (rem)
  );

  // Work RAM index: window offset folded into the RAM size; the offset is
  // below eight times the size, so three compare-and-subtract steps do it
  localparam logic [15:0] WSPAN1 = 16'(WORK_RAM_BYTES);
  localparam logic [15:0] WSPAN2 = 16'(2 * WORK_RAM_BYTES);
  localparam logic [15:0] WSPAN4 = 16'(4 * WORK_RAM_BYTES);

  logic [15:0] wofs0, wofs1, wofs2, wofs3;

  always_comb begin
    wofs0 = {3'd0, addr_r[12:0]};
    wofs1 = (wofs0 >= WSPAN4) ? (wofs0 - WSPAN4) : wofs0;
    wofs2 = (wofs1 >= WSPAN2) ? (wofs1 - WSPAN2) : wofs1;
    wofs3 = (wofs2 >= WSPAN1) ? (wofs2 - WSPAN1) : wofs2;
  end

  // Pattern index and range check
  logic [17:0] chr_idx;
  logic        chr_inside;

  assign chr_idx    = {rem[7:0], addr_r[9:0]};
  assign chr_inside = ({1'b0, chr_idx} < {chr_cnt_u, 10'd0}) &&
                      (chr_idx < 18'(PATTERN_RAM_BYTES));

  // RAM ports
  logic           in_mem;
  logic           wram_en, wram_we, pram_en, pram_we;
  logic [WAW-1:0] wram_addr;
  logic [PAW-1:0] pram_addr;
  logic [7:0]     wram_wd, pram_wd, wram_q, pram_q;

  assign in_mem = (state_r == ST_MEM);

  always_comb begin
    if (clr_busy_r) begin
      wram_en   = 1'b1;
      wram_we   = 1'b1;
      wram_addr = clr_cnt_r[WAW-1:0];
      wram_wd   = '0;
      pram_en   = 1'b1;
      pram_we   = 1'b1;
      pram_addr = clr_cnt_r[PAW-1:0];
      pram_wd   = '0;
    end else begin
      wram_en   = in_mem && ram_range && (cmd_r == CMD_CPU_RD || cmd_r == CMD_CPU_WR);
      wram_we   = (cmd_r == CMD_CPU_WR);
      wram_addr = wofs3[WAW-1:0];
      wram_wd   = data_r;
      pram_en   = in_mem && chr_ram_r &&
                  (cmd_r == CMD_PPU_RD || (cmd_r == CMD_PPU_WR && chr_inside));
      pram_we   = (cmd_r == CMD_PPU_WR);
      pram_addr = chr_idx[PAW-1:0];
      pram_wd   = data_r;
    end
  end

  bmct_ram #(.DEPTH(WORK_RAM_BYTES), .AW(WAW)) u_wram (
    .clk   (clk),
    .en    (wram_en),
    .we    (wram_we),
    .addr  (wram_addr),
    .wdata (wram_wd),
    .rdata (wram_q)
  );

  bmct_ram #(.DEPTH(PATTERN_RAM_BYTES), .AW(PAW)) u_pram (
    .clk   (clk),
    .en    (pram_en),
    .we    (pram_we),
    .addr  (pram_addr),
    .wdata (pram_wd),
    .rdata (pram_q)
  );

  // Register writes, ticks and mirroring reload from configuration
  always_comb begin
    reg_req.wr          = in_mem && (cmd_r == CMD_CPU_WR) && !ram_range;
    reg_req.tick        = in_mem && (cmd_r == CMD_TICK);
    reg_req.addr        = addr_r;
    reg_req.data        = data_r;
    reg_req.mirror_load = cfg_wr && (cfg_paddr[3:2] == CFG_MIRROR);
    reg_req.mirror_val  = cfg_pwdata[0];
  end

  // Result assembly
  logic [7:0]  res_rd;
  logic        res_rv;
  logic [20:0] res_ra;
  logic [1:0]  res_rk;
  logic [7:0]  prg_last;

  assign prg_last = 8'(prg_cnt_u - 9'd1);

  always_comb begin
    res_rd = '0;
    res_rv = 1'b0;
    res_ra = '0;
    res_rk = KIND_NONE;
    case (cmd_r)
      CMD_CPU_RD: begin
        if (ram_range) begin
          res_rd = wram_q;
          res_rv = 1'b1;
        end else if (addr_r[15]) begin
          res_ra = {(prg_fixed ? prg_last : rem[7:0]), addr_r[12:0]};
          res_rk = KIND_PRG;
        end
      end
      CMD_PPU_RD: begin
        if (chr_ram_r) begin
          res_rd = chr_inside ? pram_q : 8'd0;
          res_rv = 1'b1;
        end else begin
          res_ra = {3'd0, chr_idx};
          res_rk = KIND_CHR;
        end
      end
      default: ;
    endcase
  end

  // Output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [2:0]  out_user_r;
  logic        out_load;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= {1'b0, reg_stat.mirror, reg_stat.irq_flag, res_ra, res_rd};
      out_user_r <= {res_rk, res_rv};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = div_need ? ST_DIV : ST_MEM;
      ST_DIV:  if (!div_busy) state_nxt = ST_MEM;
      ST_MEM:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> rtl/core/bmct_checker.sv
module bmct_checker
  import bmct_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word dropped or changed under stall");

  // One event at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("event accepted while previous one in progress");

  // RAM data and ROM fetch never reported together
  a_excl_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && (out_tuser[2:1] != KIND_NONE)))
    else $error("read_valid with ROM fetch");

  // No ROM address without a ROM fetch
  a_rom_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] == KIND_NONE) |-> (out_tdata[28:8] == 21'd0))
    else $error("ROM address without fetch");

endmodule

bind bank_mapper_with_cycle_irq_timer_top bmct_checker u_bmct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> bench/bank_mapper_with_cycle_irq_timer_top_test.sv
// One bus event word and the result word it should produce
typedef struct {
  logic [2:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;
} bus_event_t;

typedef struct packed {
  logic [7:0]  read_data;
  logic        read_valid;
  logic [20:0] rom_address;
  logic [1:0]  rom_kind;
  logic        irq_line;
  logic        horiz_mirror;
} mapper_result_t;

// Mapper predictor plus the queue of results still owed by the block
class mapper_scoreboard;
  int unsigned wram_bytes = bmct_pkg::WORK_RAM_BYTES_DEF;
  int unsigned pram_bytes = bmct_pkg::PATTERN_RAM_BYTES_DEF;
  logic [15:0] wram_base  = 16'h6000;
  logic [15:0] rom_base   = 16'h8000;

  mapper_result_t owed_q[$];
  int             errors;

  // configuration copy
  logic [8:0] prg_count;
  logic [8:0] chr_count;
  logic       gfx_ram;

  // mapper state copy
  logic [5:0]  prg_bank[3];
  logic [7:0]  chr_bank[8];
  logic        mirror_state;
  logic [15:0] irq_reload;
  logic [15:0] irq_count;
  logic        latch_high;
  logic        irq_enabled;
  logic        irq_flag;
  logic [7:0]  work_ram[];
  logic [7:0]  pattern_ram[];

  function new();
    prg_count    = 9'd2;
    chr_count    = 9'd8;
    gfx_ram      = 1'b1;
    mirror_state = 1'b0;
    irq_reload   = '0;
    irq_count    = '0;
    latch_high   = 1'b0;
    irq_enabled  = 1'b0;
    irq_flag     = 1'b0;
    errors       = 0;
    foreach (prg_bank[i]) prg_bank[i] = '0;
    foreach (chr_bank[i]) chr_bank[i] = '0;
    work_ram    = new[wram_bytes];
    pattern_ram = new[pram_bytes];
    foreach (work_ram[i]) work_ram[i] = '0;
    foreach (pattern_ram[i]) pattern_ram[i] = '0;
  endfunction

  function void note_fail(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  // zero banks act as one, more than 256 as 256
  function int unsigned bank_span(logic [8:0] n);
    if (n == 9'd0) return 1;
    if (n > 9'd256) return 256;
    return n;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      bmct_pkg::CFG_PRG_COUNT:  prg_count = value[8:0];
      bmct_pkg::CFG_CHR_COUNT:  chr_count = value[8:0];
      bmct_pkg::CFG_CHR_IS_RAM: gfx_ram = value[0];
      bmct_pkg::CFG_MIRROR:     mirror_state = value[0];
      default: ;
    endcase
  endfunction

  // CPU write: work RAM store, else register decode
  function void cpu_store(logic [15:0] addr, logic [7:0] data);
    if (addr >= wram_base && addr < rom_base) begin
      work_ram[(addr - wram_base) % wram_bytes] = data;
      return;
    end
    case (addr & bmct_pkg::DECODE_MASK)
      bmct_pkg::ADDR_PRG0:   prg_bank[0] = data[5:0];
      bmct_pkg::ADDR_PRG1:   prg_bank[1] = data[5:0];
      bmct_pkg::ADDR_PRG2:   prg_bank[2] = data[5:0];
      bmct_pkg::ADDR_MIRROR: mirror_state = data[0];
      bmct_pkg::ADDR_CHR0:   chr_bank[0] = data;
      bmct_pkg::ADDR_CHR1:   chr_bank[1] = data;
      bmct_pkg::ADDR_CHR2:   chr_bank[2] = data;
      bmct_pkg::ADDR_CHR3:   chr_bank[3] = data;
      bmct_pkg::ADDR_CHR4:   chr_bank[4] = data;
      bmct_pkg::ADDR_CHR5:   chr_bank[5] = data;
      bmct_pkg::ADDR_CHR6:   chr_bank[6] = data;
      bmct_pkg::ADDR_CHR7:   chr_bank[7] = data;
      bmct_pkg::ADDR_IRQ_LATCH: begin
        // latch alternates low byte, high byte
        if (!latch_high) irq_reload[7:0] = data;
        else irq_reload[15:8] = data;
        latch_high = ~latch_high;
      end
      bmct_pkg::ADDR_IRQ_CTRL: begin
        if (data[bmct_pkg::IRQ_RESTART_BIT]) begin
          irq_enabled = 1'b1;
          irq_flag    = 1'b0;
          irq_count   = irq_reload;
        end else if (data[0]) begin
          irq_enabled = 1'b1;
          irq_count   = irq_reload;
        end else begin
          irq_enabled = 1'b0;
        end
      end
      bmct_pkg::ADDR_IRQ_ACK: irq_flag = 1'b0;
      default: ;
    endcase
  endfunction

  // accepted event: advance the state and queue the result it owes
  function void note_event(bus_event_t ev);
    mapper_result_t r;
    int unsigned    cnt;
    int unsigned    slot;
    int unsigned    bank;
    int unsigned    idx;
    logic [12:0]    ppu_addr;
    bit             in_range;
    r = '0;
    case (ev.command)
      bmct_pkg::CMD_CPU_RD: begin
        if (ev.address >= wram_base && ev.address < rom_base) begin
          r.read_data  = work_ram[(ev.address - wram_base) % wram_bytes];
          r.read_valid = 1'b1;
        end else if (ev.address >= rom_base) begin
          cnt  = bank_span(prg_count);
          slot = (ev.address - rom_base) >> 13;
          // top 8 KiB window is pinned to the last bank
          bank = (slot < 3) ? prg_bank[slot] % cnt : cnt - 1;
          r.rom_address = 21'((bank << 13) | ev.address[12:0]);
          r.rom_kind    = bmct_pkg::KIND_PRG;
        end
      end
      bmct_pkg::CMD_CPU_WR: cpu_store(ev.address, ev.write_data);
      bmct_pkg::CMD_PPU_RD, bmct_pkg::CMD_PPU_WR: begin
        ppu_addr = ev.address[12:0];
        cnt      = bank_span(chr_count);
        bank     = chr_bank[ppu_addr[12:10]] % cnt;
        idx      = (bank << 10) | ppu_addr[9:0];
        in_range = (idx < (cnt << 10)) && (idx < pram_bytes);
        if (gfx_ram) begin
          if (ev.command == bmct_pkg::CMD_PPU_RD) begin
            r.read_data  = in_range ? pattern_ram[idx] : 8'd0;
            r.read_valid = 1'b1;
          end else if (in_range) begin
            pattern_ram[idx] = ev.write_data;
          end
        end else if (ev.command == bmct_pkg::CMD_PPU_RD) begin
          r.rom_address = 21'(idx);
          r.rom_kind    = bmct_pkg::KIND_CHR;
        end
      end
      bmct_pkg::CMD_TICK: begin
        if (irq_count == 16'd0) begin
          irq_count = irq_reload;
          if (irq_enabled) irq_flag = 1'b1;
        end else begin
          irq_count = irq_count - 16'd1;
        end
      end
      default: ;
    endcase
    r.irq_line     = irq_flag;
    r.horiz_mirror = mirror_state;
    owed_q.push_back(r);
  endfunction

  // compare one result word against the oldest owed result
  function void check_word(logic [31:0] tdata, logic [2:0] tuser);
    mapper_result_t got;
    mapper_result_t exp;
    bit             bad;
    got.read_data    = tdata[7:0];
    got.rom_address  = tdata[28:8];
    got.irq_line     = tdata[29];
    got.horiz_mirror = tdata[30];
    got.read_valid   = tuser[0];
    got.rom_kind     = tuser[2:1];
    if (owed_q.size() == 0) begin
      note_fail($sformatf("unexpected result word tdata=%h tuser=%h", tdata, tuser));
      return;
    end
    exp = owed_q.pop_front();
    bad = (got.read_data !== exp.read_data) || (got.read_valid !== exp.read_valid) ||
          (got.rom_address !== exp.rom_address) || (got.rom_kind !== exp.rom_kind) ||
          (got.irq_line !== exp.irq_line) ||
          (got.horiz_mirror !== exp.horiz_mirror);
    if (bad)
      note_fail($sformatf({"mismatch: exp rd=%h rv=%b ra=%h rk=%0d irq=%b mir=%b",
                           " / got rd=%h rv=%b ra=%h rk=%0d irq=%b mir=%b"},
                          exp.read_data, exp.read_valid, exp.rom_address, exp.rom_kind,
                          exp.irq_line, exp.horiz_mirror,
                          got.read_data, got.read_valid, got.rom_address, got.rom_kind,
                          got.irq_line, got.horiz_mirror));
  endfunction
endclass

module bank_mapper_with_cycle_irq_timer_top_test
  import bmct_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 40000;
  localparam int PHASE_WORDS = 290;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;  // address[15:0], write_data[23:16]
  logic [2:0]  in_tuser    = '0;  // command[2:0]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;         // read_data[7:0], rom_address[28:8], irq[29], mirror[30]
  logic [2:0]  out_tuser;         // read_valid[0], rom_kind[2:1]
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mapper_scoreboard sb;
  bus_event_t       plan_q[$];
  int               words_sent;
  int               send_idle_pct = 22;
  int               recv_idle_pct = 45;
  int               quiet_cycles  = 0;

  bank_mapper_with_cycle_irq_timer_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random backpressure, check every accepted word
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bank_mapper_with_cycle_irq_timer_top verification failed");
      $finish;
    end
  end

  // idling schedule: sender-light first, then swapped, then none
  function void pick_idling();
    if (words_sent < 700) begin
      send_idle_pct = 22;
      recv_idle_pct = 45;
    end else if (words_sent < 1400) begin
      send_idle_pct = 45;
      recv_idle_pct = 22;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  task automatic send_word(bus_event_t ev);
    pick_idling();
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ev.write_data, ev.address};
    in_tuser  <= ev.command;
    do @(posedge clk); while (!in_tready);
    sb.note_event(ev);
    words_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // bus idle between transfers
    @(posedge clk);
  endtask

  // hold off input until the block owes nothing
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function void plan(logic [2:0] cmd, logic [15:0] addr, logic [7:0] data);
    bus_event_t ev;
    ev.command    = cmd;
    ev.address    = addr;
    ev.write_data = data;
    plan_q.push_back(ev);
  endfunction

  // register address with the don't-care decode bits scrambled
  function logic [15:0] reg_alias(logic [15:0] base);
    return base | (16'($urandom) & ~DECODE_MASK);
  endfunction

  function void plan_random();
    int          pick;
    int          n;
    logic [15:0] regs[15];
    pick = $urandom_range(0, 99);
    regs = '{ADDR_PRG0, ADDR_PRG1, ADDR_PRG2, ADDR_MIRROR, ADDR_CHR0, ADDR_CHR1,
             ADDR_CHR2, ADDR_CHR3, ADDR_CHR4, ADDR_CHR5, ADDR_CHR6, ADDR_CHR7,
             ADDR_IRQ_LATCH, ADDR_IRQ_CTRL, ADDR_IRQ_ACK};
    if (pick < 10) begin
      // IRQ program: latch low/high, control, some ticks, maybe ack
      plan(CMD_CPU_WR, reg_alias(ADDR_IRQ_LATCH), 8'($urandom_range(0, 15)));
      plan(CMD_CPU_WR, reg_alias(ADDR_IRQ_LATCH),
           ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0);
      plan(CMD_CPU_WR, reg_alias(ADDR_IRQ_CTRL), 8'($urandom));
      n = $urandom_range(1, 20);
      repeat (n) plan(CMD_TICK, 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 1)) plan(CMD_CPU_WR, reg_alias(ADDR_IRQ_ACK), 8'($urandom));
    end else if (pick < 22) begin
      plan(CMD_CPU_WR, reg_alias(regs[$urandom_range(0, 14)]), 8'($urandom));
    end else if (pick < 30) begin
      plan(CMD_CPU_WR, 16'h6000 + 16'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, 8191)),
           8'($urandom));
    end else if (pick < 40) begin
      plan(CMD_CPU_RD, 16'h6000 + 16'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, 8191)),
           8'($urandom));
    end else if (pick < 55) begin
      plan(CMD_CPU_RD, 16'h8000 + 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
    end else if (pick < 58) begin
      plan(CMD_CPU_RD, 16'($urandom_range(0, 16'h5FFF)), 8'($urandom));
    end else if (pick < 76) begin
      // PPU access; half of them crowd into a few bytes per bank window
      plan((pick < 66) ? CMD_PPU_WR : CMD_PPU_RD,
           $urandom_range(0, 1) ? ((16'($urandom) & 16'hFC00) | 16'($urandom_range(0, 15)))
                                : 16'($urandom),
           8'($urandom));
    end else if (pick < 96) begin
      plan(CMD_TICK, 16'($urandom), 8'($urandom));
    end else if (pick < 98) begin
      plan(CMD_CPU_WR, 16'($urandom), 8'($urandom));
    end else begin
      // unused command codes
      plan(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom));
    end
  endfunction

  task automatic run_phase(logic [31:0] prg, logic [31:0] chr, logic [31:0] ram,
                           logic [31:0] mir, int count);
    int target;
    drain();
    cfg_write(CFG_PRG_COUNT, prg);
    cfg_write(CFG_CHR_COUNT, chr);
    cfg_write(CFG_CHR_IS_RAM, ram);
    cfg_write(CFG_MIRROR, mir);
    @(posedge clk);
    target = words_sent + count;
    while (words_sent < target) begin
      if (plan_q.size() == 0) plan_random();
      send_word(plan_q.pop_front());
      // one pause mid-run until every result is back
      if (words_sent == 1000) drain();
    end
  endtask

  initial begin
    sb = new();
    words_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass at reset configuration (2 program, 8 graphics banks, RAM)
    plan(CMD_CPU_RD, 16'h0000, 8'hFF);          // below work RAM: nothing
    plan(CMD_CPU_WR, 16'h6000, 8'hFF);
    plan(CMD_CPU_RD, 16'h6000, 8'h00);
    plan(CMD_CPU_WR, 16'h7FFF, 8'h5A);
    plan(CMD_CPU_RD, 16'h7FFF, 8'h00);
    plan(CMD_CPU_WR, ADDR_PRG0, 8'hFF);          // bank 63 wraps to 1
    plan(CMD_CPU_RD, 16'h8000, 8'h00);
    plan(CMD_CPU_WR, ADDR_PRG2 | 16'h0FC2, 8'h03);
    plan(CMD_CPU_RD, 16'hC123, 8'h00);
    plan(CMD_CPU_RD, 16'hFFFF, 8'h00);          // fixed last bank
    plan(CMD_CPU_WR, ADDR_MIRROR, 8'h01);
    plan(CMD_CPU_WR, ADDR_CHR7, 8'hFF);
    plan(CMD_PPU_WR, 16'h1FFF, 8'hA5);
    plan(CMD_PPU_RD, 16'hFFFF, 8'h00);          // upper address bits ignored
    plan(CMD_CPU_WR, ADDR_IRQ_LATCH, 8'h02);
    plan(CMD_CPU_WR, ADDR_IRQ_LATCH, 8'h00);
    plan(CMD_CPU_WR, ADDR_IRQ_CTRL, 8'h01);
    plan(CMD_TICK, 16'hFFFF, 8'hFF);
    plan(CMD_TICK, 16'h0000, 8'h00);
    plan(CMD_TICK, 16'h0000, 8'h00);            // reload, flag rises
    plan(CMD_CPU_WR, ADDR_IRQ_ACK, 8'h00);
    plan(CMD_CPU_WR, ADDR_IRQ_CTRL | 16'h0002, 8'h02);
    plan(CMD_CPU_WR, ADDR_IRQ_CTRL, 8'h00);
    plan(CMD_CPU_WR, 16'h5000, 8'h77);          // unmapped write
    plan(3'd7, 16'hFFFF, 8'hFF);                // unused command
    while (plan_q.size() != 0) send_word(plan_q.pop_front());

    // random phases across settings, extremes first
    run_phase(32'd256, 32'd256, 32'd0, 32'd1, PHASE_WORDS);
    run_phase(32'd1, 32'd1, 32'd1, 32'd0, PHASE_WORDS);
    run_phase(32'd0, 32'd0, 32'd0, 32'd1, PHASE_WORDS);
    run_phase(32'd511, 32'd257, 32'd1, 32'd1, PHASE_WORDS);
    run_phase(32'd3, 32'd5, 32'd1, 32'd0, PHASE_WORDS);
    run_phase($urandom, $urandom, $urandom, $urandom, PHASE_WORDS);
    run_phase($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1),
              $urandom_range(0, 1), PHASE_WORDS);
    plan_q.delete();

    drain();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) sb.note_fail("results still owed at end of run");
    if (sb.errors == 0)
      $display("bank_mapper_with_cycle_irq_timer_top verification clean");
    else
      $display("bank_mapper_with_cycle_irq_timer_top verification failed");
    $finish;
  end

endmodule
